FILE: hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table: command and status
// codes, sequencer states, field widths and the compare result bundle.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int KEY_W        = 32;
    localparam int HANDLE_W     = 16;
    localparam int COUNT_W      = 9;
    localparam int ENTRY_W      = KEY_W + HANDLE_W;
    localparam int CAPACITY_DEF = 256;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NO_OBJ  = 2'd1,
        STS_FULL    = 2'd2,
        STS_UNUSED  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LK_PROBE,
        ST_LK_CMP,
        ST_INS_READ,
        ST_INS_CMP,
        ST_DONE
    } state_t;

    // Result of comparing the request key against a probed table key
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } cmp_t;

endpackage

FILE: hw/rtl/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/skt_cmp.sv
// ----------------------------------------------------------------------------
// skt_cmp
// Shared key comparator used by both the lookup search and the insert shift.
// ----------------------------------------------------------------------------
module skt_cmp (
    input  logic [skt_pkg::KEY_W-1:0] req_key,
    input  logic [skt_pkg::KEY_W-1:0] probe_key,
    output skt_pkg::cmp_t             result
);
    import skt_pkg::*;

    // Order the request key against the probed key
    always_comb
    begin
        result.lt = (req_key < probe_key);
        result.eq = (req_key == probe_key);
        result.gt = (req_key > probe_key);
    end

endmodule

FILE: hw/rtl/sorted_key_table_lookup.sv
// Lookup: binary search over the live entries, one RAM read per probe.
// Insert: each larger entry is moved up one slot, then the new one is written;
//   a full table is refused with the full status.
// Throughput: one request at a time; the next is taken while a result waits.
// Reset: entry count and control clear; the table RAM is not cleared.
// ----------------------------------------------------------------------------
// sorted_key_table_lookup
// Sorted object-dictionary index table with binary-search lookup and
// shift-in-place insert, sequenced over one RAM and one comparator.
// ----------------------------------------------------------------------------
module sorted_key_table_lookup #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   cmd,
    input  logic [skt_pkg::KEY_W-1:0]    key,
    input  logic [skt_pkg::HANDLE_W-1:0] entry_handle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [skt_pkg::HANDLE_W-1:0] found_handle,
    output logic [skt_pkg::COUNT_W-1:0]  count
);
    import skt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = CW + COUNT_W;

    state_t               state_reg, state_next;
    logic [CW-1:0]        entry_count_reg, entry_count_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [HANDLE_W-1:0]  handle_reg, handle_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [AW-1:0]        mid_reg, mid_next;
    logic [CW-1:0]        idx_reg, idx_next;
    status_t              res_status_reg, res_status_next;
    logic [HANDLE_W-1:0]  res_handle_reg, res_handle_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [HANDLE_W-1:0]  out_handle_reg, out_handle_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [KEY_W-1:0]     probe_key;
    logic [HANDLE_W-1:0]  probe_handle;
    cmp_t                 cmp;

    logic [CW:0]          mid_sum;
    logic [AW-1:0]        mid_calc;
    logic [CW-1:0]        idx_dec;
    logic [EW-1:0]        count_wide;
    logic                 out_free;

    // Table storage: {key, handle} per entry
    skt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign probe_key    = ram_rdata[ENTRY_W-1:HANDLE_W];
    assign probe_handle = ram_rdata[HANDLE_W-1:0];

    // Shared comparator
    skt_cmp u_cmp (
        .req_key   (key_reg),
        .probe_key (probe_key),
        .result    (cmp)
    );

    // Midpoint of the live window [lo, hi)
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg} - {{CW{1'b0}}, 1'b1};
    assign mid_calc   = mid_sum[AW:1];
    assign idx_dec    = idx_reg - {{(CW-1){1'b0}}, 1'b1};
    assign count_wide = EW'(entry_count_reg);
    assign out_free   = !out_valid_reg || out_ready;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Hold payload and search state
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        handle_reg     <= handle_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
        out_count_reg  <= out_count_next;
    end

    // Sequencer: next state, RAM control and result
    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        key_next         = key_reg;
        handle_next      = handle_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        idx_next         = idx_reg;
        res_status_next  = res_status_reg;
        res_handle_next  = res_handle_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_handle_next  = out_handle_reg;
        out_count_next   = out_count_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg[AW-1:0];
        ram_wdata        = {key_reg, handle_reg};
        ram_raddr        = mid_calc;
        in_ready         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    key_next        = key;
                    handle_next     = entry_handle;
                    res_status_next = STS_OK;
                    res_handle_next = '0;
                    case (cmd_t'(cmd))
                        CMD_CLEAR:
                        begin
                            entry_count_next = '0;
                            state_next       = ST_DONE;
                        end
                        CMD_INSERT:
                        begin
                            if (entry_count_reg >= CW'(CAPACITY))
                            begin
                                res_status_next = STS_FULL;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                idx_next   = entry_count_reg;
                                state_next = ST_INS_READ;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            lo_next    = '0;
                            hi_next    = entry_count_reg;
                            state_next = ST_LK_PROBE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_LK_PROBE:
            begin
                // Issue a read at the midpoint, or give up on an empty window
                if (lo_reg < hi_reg)
                begin
                    ram_raddr  = mid_calc;
                    mid_next   = mid_calc;
                    state_next = ST_LK_CMP;
                end
                else
                begin
                    res_status_next = STS_NO_OBJ;
                    state_next      = ST_DONE;
                end
            end

            ST_LK_CMP:
            begin
                // Narrow the window toward the key
                if (cmp.lt)
                begin
                    hi_next    = CW'(mid_reg);
                    state_next = ST_LK_PROBE;
                end
                else if (cmp.gt)
                begin
                    lo_next    = CW'(mid_reg) + {{(CW-1){1'b0}}, 1'b1};
                    state_next = ST_LK_PROBE;
                end
                else
                begin
                    res_handle_next = probe_handle;
                    state_next      = ST_DONE;
                end
            end

            ST_INS_READ:
            begin
                // At the bottom: drop the new entry in place
                if (idx_reg == '0)
                begin
                    ram_we           = 1'b1;
                    entry_count_next = entry_count_reg + {{(CW-1){1'b0}}, 1'b1};
                    state_next       = ST_DONE;
                end
                else
                begin
                    ram_raddr  = idx_dec[AW-1:0];
                    state_next = ST_INS_CMP;
                end
            end

            ST_INS_CMP:
            begin
                // Move a larger entry up one slot, else place the new one here
                ram_we = 1'b1;
                if (cmp.lt)
                begin
                    ram_wdata  = ram_rdata;
                    idx_next   = idx_dec;
                    state_next = ST_INS_READ;
                end
                else
                begin
                    entry_count_next = entry_count_reg + {{(CW-1){1'b0}}, 1'b1};
                    state_next       = ST_DONE;
                end
            end

            ST_DONE:
            begin
                // Load the output register once it is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    out_count_next  = count_wide[COUNT_W-1:0];
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign found_handle = out_handle_reg;
    assign count        = out_count_reg;

endmodule

FILE: hw/rtl/skt_checker.sv
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks on the sorted key table results, bound to the top level.
// ----------------------------------------------------------------------------
module skt_checker #(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [1:0]                   status,
    input logic [skt_pkg::HANDLE_W-1:0] found_handle,
    input logic [skt_pkg::COUNT_W-1:0]  count
);
    import skt_pkg::*;

    localparam logic [COUNT_W-1:0] CAP_LOW = COUNT_W'(CAPACITY);

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(found_handle) && $stable(count))
    else $error("stalled result changed");

    // Status is never the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != STS_UNUSED)
    else $error("unused status code");

    // A handle is returned only with success
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STS_OK |-> found_handle == '0)
    else $error("handle on failed request");

    // Full is reported only at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STS_FULL |-> count == CAP_LOW)
    else $error("full reported below capacity");

endmodule

bind sorted_key_table_lookup skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_handle (found_handle),
    .count        (count)
);

FILE: sim/sorted_key_table_lookup_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_table_lookup_tb
// Self-checking bench for the sorted key table. It runs a short directed
// sweep of table states, then random phases of mixed traffic and table
// fills up to capacity. Every reply is checked field by field against a
// directed or modeled reply, mostly under random request gaps and stalls.
// ----------------------------------------------------------------------------
module sorted_key_table_lookup_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int REQ_TARGET   = 1900;
    localparam int DRAIN_CYCLES = 600;

    typedef struct {
        status_t              st;
        logic [HANDLE_W-1:0]  fh;
        logic [COUNT_W-1:0]   cnt;
    } table_reply_t;

    typedef struct {
        cmd_t                 op;
        logic [KEY_W-1:0]     k;
        logic [HANDLE_W-1:0]  h;
        bit                   typed;
        table_reply_t         reply;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          cmd;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] entry_handle;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] found_handle;
    logic [COUNT_W-1:0]  count;

    // Mirror of the table contents
    logic [KEY_W-1:0]    model_keys [TABLE_DEPTH];
    logic [HANDLE_W-1:0] model_handles [TABLE_DEPTH];
    int unsigned         model_count;

    table_reply_t        awaited_replies [$];
    int                  error_count = 0;
    int                  req_count = 0;
    int                  burst_left = 0;
    bit                  gaps_on = 1'b1;
    int                  ready_mode = 0;
    int                  stall_left = 0;
    dir_row_t            directed_rows [21];

    sorted_key_table_lookup u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .key          (key),
        .entry_handle (entry_handle),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .found_handle (found_handle),
        .count        (count)
    );

    always #1 clk = ~clk;

    // Apply one request to the mirror table and return the reply it gives
    function automatic table_reply_t apply_table_op(cmd_t op, logic [KEY_W-1:0] k,
                                                    logic [HANDLE_W-1:0] h);
        table_reply_t r;
        int           lo;
        int           hi;
        int           mid;
        int unsigned  pos;
        r.st  = STS_OK;
        r.fh  = '0;
        case (op)
            CMD_CLEAR:
            begin
                model_count = 0;
            end
            CMD_INSERT:
            begin
                if (model_count >= TABLE_DEPTH)
                begin
                    r.st = STS_FULL;
                end
                else
                begin
                    // upper bound keeps equal keys in arrival order
                    pos = 0;
                    while (pos < model_count && model_keys[pos] <= k)
                        pos++;
                    for (int unsigned i = model_count; i > pos; i--)
                    begin
                        model_keys[i]    = model_keys[i-1];
                        model_handles[i] = model_handles[i-1];
                    end
                    model_keys[pos]    = k;
                    model_handles[pos] = h;
                    model_count++;
                end
            end
            CMD_LOOKUP:
            begin
                // midpoint search, stop at the first equal probe
                r.st = STS_NO_OBJ;
                lo = 0;
                hi = int'(model_count) - 1;
                while (lo <= hi)
                begin
                    mid = (lo + hi) / 2;
                    if (k < model_keys[mid])
                        hi = mid - 1;
                    else if (k > model_keys[mid])
                        lo = mid + 1;
                    else
                    begin
                        r.st = STS_OK;
                        r.fh = model_handles[mid];
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.cnt = model_count[COUNT_W-1:0];
        return r;
    endfunction

    // Lookup keys: mostly present, some neighbors of present keys, some random
    function automatic logic [KEY_W-1:0] pick_lookup_key();
        int               r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        k = $urandom;
        if (model_count != 0 && r < 80)
        begin
            k = model_keys[$urandom_range(0, model_count - 1)];
            if (r >= 60)
                k = (r & 1) ? k + 1 : k - 1;
        end
        return k;
    endfunction

    // Insert keys: duplicates from a narrow range, copies, extremes and random
    function automatic logic [KEY_W-1:0] pick_insert_key();
        int               r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        k = $urandom;
        if (r < 25)
            k = $urandom_range(0, 63);
        else if (r < 40 && model_count != 0)
            k = model_keys[$urandom_range(0, model_count - 1)];
        else if (r < 45)
            k = (r & 1) ? '1 : '0;
        return k;
    endfunction

    // Hold the request channel idle for a number of cycles
    task automatic hold_off(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    // Present one request, wait for acceptance, then record its reply
    task automatic send_request(cmd_t op, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h,
                                bit typed, table_reply_t typed_reply);
        table_reply_t r;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                hold_off($urandom_range(1, 6));
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        @(negedge clk);
        in_valid     = 1'b1;
        cmd          = op;
        key          = k;
        entry_handle = h;
        do
            @(posedge clk);
        while (!in_ready);
        r = apply_table_op(op, k, h);
        awaited_replies.push_back(typed ? typed_reply : r);
        if (op != CMD_NOP)
            req_count++;
    endtask

    task automatic send_random(cmd_t op);
        table_reply_t none;
        none = '{STS_OK, '0, '0};
        send_request(op, (op == CMD_INSERT) ? pick_insert_key() : pick_lookup_key(),
                     HANDLE_W'($urandom), 1'b0, none);
    endtask

    // Stall the reply channel on a mode-dependent pattern
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            case (ready_mode)
                1:
                begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        stall_left <= $urandom_range(1, 3);
                end
                2:
                begin
                    out_ready <= ($urandom_range(0, 9) < 6);
                end
                3:
                begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        stall_left <= $urandom_range(4, 24);
                end
                default:
                begin
                    out_ready <= 1'b1;
                end
            endcase
        end
    end

    // Compare each reply with the oldest awaited one
    always @(posedge clk)
    begin
        table_reply_t exp_reply;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("unexpected reply: status %0d found_handle 0x%04h count %0d",
                       status, found_handle, count);
                error_count++;
            end
            else
            begin
                exp_reply = awaited_replies.pop_front();
                if (status !== exp_reply.st)
                begin
                    $error("status: expected %0d, got %0d", exp_reply.st, status);
                    error_count++;
                end
                if (found_handle !== exp_reply.fh)
                begin
                    $error("found_handle: expected 0x%04h, got 0x%04h", exp_reply.fh,
                           found_handle);
                    error_count++;
                end
                if (count !== exp_reply.cnt)
                begin
                    $error("count: expected %0d, got %0d", exp_reply.cnt, count);
                    error_count++;
                end
            end
        end
    end

    // Abort a hung run
    initial
    begin
        #10_000_000;
        $display("sorted_key_table_lookup: mismatch");
        $finish;
    end

    initial
    begin
        int r;
        int phase;
        table_reply_t none;

        none         = '{STS_OK, '0, '0};
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = CMD_CLEAR;
        key          = '0;
        entry_handle = '0;
        model_count  = 0;

        // Directed sweep: empty table, extremes, duplicates, unused code, clear
        directed_rows = '{
            '{CMD_LOOKUP, 32'h0000_0000, 16'h0000, 1'b1, '{STS_NO_OBJ, 16'h0000, 9'd0}},
            '{CMD_CLEAR,  32'h0000_0000, 16'h0000, 1'b1, '{STS_OK,     16'h0000, 9'd0}},
            '{CMD_NOP,    32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{STS_OK,     16'h0000, 9'd0}},
            '{CMD_INSERT, 32'h0000_0000, 16'hFFFF, 1'b1, '{STS_OK,     16'h0000, 9'd1}},
            '{CMD_INSERT, 32'hFFFF_FFFF, 16'h0000, 1'b1, '{STS_OK,     16'h0000, 9'd2}},
            '{CMD_LOOKUP, 32'h0000_0000, 16'h1111, 1'b1, '{STS_OK,     16'hFFFF, 9'd2}},
            '{CMD_LOOKUP, 32'hFFFF_FFFF, 16'h2222, 1'b1, '{STS_OK,     16'h0000, 9'd2}},
            '{CMD_LOOKUP, 32'h0000_0001, 16'h0000, 1'b1, '{STS_NO_OBJ, 16'h0000, 9'd2}},
            '{CMD_LOOKUP, 32'hFFFF_FFFE, 16'h0000, 1'b1, '{STS_NO_OBJ, 16'h0000, 9'd2}},
            '{CMD_INSERT, 32'h8000_0000, 16'h5555, 1'b1, '{STS_OK,     16'h0000, 9'd3}},
            '{CMD_INSERT, 32'h8000_0000, 16'hAAAA, 1'b1, '{STS_OK,     16'h0000, 9'd4}},
            '{CMD_INSERT, 32'h8000_0000, 16'h1234, 1'b1, '{STS_OK,     16'h0000, 9'd5}},
            '{CMD_LOOKUP, 32'h8000_0000, 16'h0000, 1'b0, none},
            '{CMD_INSERT, 32'h7FFF_FFFF, 16'h00FF, 1'b1, '{STS_OK,     16'h0000, 9'd6}},
            '{CMD_LOOKUP, 32'h7FFF_FFFF, 16'h0000, 1'b1, '{STS_OK,     16'h00FF, 9'd6}},
            '{CMD_INSERT, 32'h0000_0000, 16'h0001, 1'b1, '{STS_OK,     16'h0000, 9'd7}},
            '{CMD_LOOKUP, 32'h0000_0000, 16'h0000, 1'b0, none},
            '{CMD_NOP,    32'h1234_5678, 16'hABCD, 1'b1, '{STS_OK,     16'h0000, 9'd7}},
            '{CMD_LOOKUP, 32'h8000_0001, 16'h0000, 1'b1, '{STS_NO_OBJ, 16'h0000, 9'd7}},
            '{CMD_CLEAR,  32'hDEAD_BEEF, 16'hBEEF, 1'b1, '{STS_OK,     16'h0000, 9'd0}},
            '{CMD_LOOKUP, 32'h8000_0000, 16'h0000, 1'b1, '{STS_NO_OBJ, 16'h0000, 9'd0}}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        ready_mode = 1;
        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].k, directed_rows[i].h,
                         directed_rows[i].typed, directed_rows[i].reply);

        // Random phases: mixed traffic, with a fill to capacity every few phases
        phase = 0;
        while (req_count < REQ_TARGET)
        begin
            gaps_on    = (phase % 4 != 0);
            ready_mode = gaps_on ? $urandom_range(1, 3) : 0;
            if (phase % 5 == 2)
            begin
                send_request(CMD_CLEAR, $urandom, HANDLE_W'($urandom), 1'b0, none);
                while (model_count < TABLE_DEPTH)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_random(CMD_LOOKUP);
                    else
                        send_random(CMD_INSERT);
                end
                repeat (40)
                    send_random(($urandom_range(0, 3) == 0) ? CMD_INSERT : CMD_LOOKUP);
            end
            else
            begin
                repeat (150)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        send_random(CMD_INSERT);
                    else if (r < 95)
                        send_random(CMD_LOOKUP);
                    else if (r < 97)
                        send_random(CMD_CLEAR);
                    else
                        send_random(CMD_NOP);
                end
            end
            phase++;
        end

        @(negedge clk);
        in_valid = 1'b0;

        // Drain outstanding replies, then watch for strays
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && awaited_replies.size() == 0)
            $display("sorted_key_table_lookup: match");
        else
            $display("sorted_key_table_lookup: mismatch");
        $finish;
    end

endmodule
